[rtl/fir_pkg.sv]
`default_nettype none

package fir_pkg;

    localparam int MAX_TAPS_DEF = 64;

    localparam int SAMPLE_W  = 32;
    localparam int KIND_W    = 2;
    localparam int TAP_IDX_W = 6;
    localparam int TAPCNT_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int FRAC_W    = 27;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0]           kind;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [SAMPLE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  filtered_sample;
        logic                        saturated;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/fir_filter_q4_27.sv]
// Direct-form FIR filter on signed Q4.27 samples.
// Input channel: i_in_valid / o_in_stall / i_in_data. An item transfers at a
// rising edge with i_in_valid high and o_in_stall low. Kind sample filters
// (or bypasses) and yields one result; kind coefficient loads one tap; kind
// clear zeroes the history of the taps in use; other kinds are dropped.
// Output channel: o_out_valid / i_out_stall / o_out_data, held in an output
// register; the next item is taken while a result waits there.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 tap count, 1 filter enable) at the clock edge; write only while idle.
// A filtered sample runs one multiply-accumulate per tap per cycle over the
// n taps in use, fed from the single read port of each of the history and
// coefficient RAMs.
// Reset (synchronous, active low) resets the control registers and then
// sweeps all MAX_TAPS history RAM entries to zero while o_in_stall is high.
// If the receiver stalls, the result is held; a later finished result waits
// inside the block until the output register frees up.
`default_nettype none

module fir_filter_q4_27 #(
    parameter int MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire fir_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output fir_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [fir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fir_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    import fir_pkg::*;

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int NW    = (CW > TAPCNT_W) ? CW : TAPCNT_W;
    localparam int IW    = (CW > TAP_IDX_W) ? CW : TAP_IDX_W;
    localparam int ACC_W = 2 * SAMPLE_W + CW;
    localparam int TOP_L = FRAC_W + SAMPLE_W - 1;

    typedef enum logic [4:0] {
        S_CLR   = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [TAPCNT_W-1:0]        r_tap_count;
    logic                       r_filt_en;
    logic [AW-1:0]              r_wpos;
    logic [CW-1:0]              r_clr_cnt;
    logic [CW-1:0]              r_clr_end;
    logic [CW-1:0]              r_k;
    logic [AW-1:0]              r_idx;
    logic                       r_rd_v, r_rd_last;
    logic                       r_mul_v, r_mul_last;
    logic                       r_acc_done;
    logic signed [2*SAMPLE_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    t_out_item                  r_res;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic [CW-1:0]              taps;
    logic [AW-1:0]              wr_pos;
    logic [CW-1:0]              wr_pos_inc;
    logic [AW-1:0]              next_wpos;
    logic                       in_xfer;
    logic                       filt_on;
    logic                       out_free;
    logic [CW-1:0]              k_inc;
    logic [CW-1:0]              idx_inc;
    logic                       hist_we;
    logic [AW-1:0]              hist_waddr;
    logic [SAMPLE_W-1:0]        hist_wdata;
    logic                       coef_we;
    logic [SAMPLE_W-1:0]        hist_rdata;
    logic [SAMPLE_W-1:0]        coef_rdata;
    logic [ACC_W-1:TOP_L]       acc_top;

    assign taps = (NW'(r_tap_count) > NW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(r_tap_count);
    assign filt_on = r_filt_en && (taps != '0);
    assign wr_pos = (CW'(r_wpos) < taps) ? r_wpos : '0;
    assign wr_pos_inc = CW'(wr_pos) + CW'(1);
    assign next_wpos = (wr_pos_inc < taps) ? AW'(wr_pos_inc) : '0;
    assign in_xfer = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign k_inc = r_k + CW'(1);
    assign idx_inc = CW'(r_idx) + CW'(1);
    assign acc_top = r_acc[ACC_W-1:TOP_L];

    always_comb begin
        hist_we = 1'b0;
        hist_waddr = wr_pos;
        hist_wdata = i_in_data.value;
        if (r_state == S_CLR) begin
            hist_we = 1'b1;
            hist_waddr = r_clr_cnt[AW-1:0];
            hist_wdata = '0;
        end else if (in_xfer && i_in_data.kind == KIND_SAMPLE && filt_on) begin
            hist_we = 1'b1;
        end
    end

    assign coef_we = in_xfer && (i_in_data.kind == KIND_COEF) &&
                     (IW'(i_in_data.tap_index) < IW'(MAX_TAPS));

    fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(r_idx),
        .o_rdata(hist_rdata)
    );

    fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(AW'(i_in_data.tap_index)),
        .i_wdata(i_in_data.value),
        .i_raddr(r_k[AW-1:0]),
        .o_rdata(coef_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr_cnt + CW'(1) >= r_clr_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.kind)
                        KIND_SAMPLE: n_state = filt_on ? S_RUN : S_OUT;
                        KIND_CLEAR:  n_state = (taps != '0) ? S_CLR : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN: begin
                if (k_inc >= taps) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_acc_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_tap_count <= '0;
            r_filt_en   <= 1'b0;
            r_wpos      <= '0;
            r_clr_cnt   <= '0;
            r_clr_end   <= CW'(MAX_TAPS);
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_mul_v     <= 1'b0;
            r_mul_last  <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAPCNT_W-1:0];
                    CFG_FILTER_EN: r_filt_en   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end

            r_rd_v     <= (r_state == S_RUN);
            r_rd_last  <= (r_state == S_RUN) && (k_inc >= taps);
            r_mul_v    <= r_rd_v;
            r_mul_last <= r_rd_last;
            r_acc_done <= r_mul_last;

            if (in_xfer) begin
                case (i_in_data.kind)
                    KIND_SAMPLE: begin
                        if (filt_on) begin
                            r_wpos <= next_wpos;
                        end
                    end
                    KIND_CLEAR: begin
                        r_wpos    <= '0;
                        r_clr_cnt <= '0;
                        r_clr_end <= taps;
                    end
                    default: ;
                endcase
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_k   <= '0;
            r_idx <= next_wpos;
            r_acc <= '0;
            r_res.filtered_sample <= i_in_data.value;
            r_res.saturated       <= 1'b0;
        end else begin
            if (r_state == S_RUN) begin
                r_k   <= k_inc;
                r_idx <= (idx_inc < taps) ? AW'(idx_inc) : '0;
            end
            if (r_mul_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_state == S_DRAIN && r_acc_done) begin
                if (&acc_top || !(|acc_top)) begin
                    r_res.filtered_sample <= r_acc[TOP_L:FRAC_W];
                    r_res.saturated       <= 1'b0;
                end else begin
                    r_res.filtered_sample <= acc_top[ACC_W-1]
                        ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
                    r_res.saturated       <= 1'b1;
                end
            end
        end

        r_prod <= $signed(hist_rdata) * $signed(coef_rdata);

        if (r_state == S_OUT && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[rtl/fir_ram.sv]
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fir_pkg::*;

    localparam int MAX_TAPS = MAX_TAPS_DEF;
    localparam int SETTLE_CYCLES = MAX_TAPS + 10;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 450;
    localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;
    localparam logic signed [79:0] SAT_HI = 80'sh7FFF_FFFF;
    localparam logic signed [79:0] SAT_LO = -80'sh8000_0000;

    typedef struct packed {
        logic                cfg;
        logic [TAPCNT_W-1:0] taps;
        logic                en;
        t_in_item            item;
        logic                typed;
        t_out_item           res;
    } t_dir_row;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
    int                         wr_pos;
    logic [TAPCNT_W-1:0]        cfg_taps;
    logic                       cfg_en;

    t_out_item filtered_q [$];
    int        err_count = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    bit        hold_off_req = 1'b0;

    fir_filter_q4_27 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_dir_row dir_row(logic cfg, logic [TAPCNT_W-1:0] taps, logic en,
                                         logic [KIND_W-1:0] kind, logic [TAP_IDX_W-1:0] idx,
                                         logic [SAMPLE_W-1:0] value, logic typed,
                                         logic [SAMPLE_W-1:0] res_val, logic res_sat);
        t_dir_row r;
        r.cfg = cfg;
        r.taps = taps;
        r.en = en;
        r.item.kind = kind;
        r.item.tap_index = idx;
        r.item.value = value;
        r.typed = typed;
        r.res.filtered_sample = res_val;
        r.res.saturated = res_sat;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_word();
        logic [SAMPLE_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2: w = '0;
            3, 4: w = $urandom;
            default: w = $signed($urandom) >>> $urandom_range(4, 12);
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string field, input logic [SAMPLE_W-1:0] exp_v,
                                   input logic [SAMPLE_W-1:0] got_v);
        $display("ERROR t=%0t %s: expected %h got %h", $realtime, field, exp_v, got_v);
        err_count++;
    endtask

    task automatic apply_item(input t_in_item it, output bit has_out, output t_out_item res);
        int n;
        int p;
        int j;
        logic signed [79:0] acc;
        logic signed [79:0] prod;
        logic signed [79:0] sh;
        has_out = 1'b0;
        res = '0;
        n = (cfg_taps > MAX_TAPS) ? MAX_TAPS : int'(cfg_taps);
        case (it.kind)
            KIND_COEF: begin
                coef_mem[it.tap_index] = it.value;
            end
            KIND_CLEAR: begin
                wr_pos = 0;
                for (int i = 0; i < n; i++) hist_mem[i] = '0;
            end
            KIND_SAMPLE: begin
                has_out = 1'b1;
                if (n == 0 || !cfg_en) begin
                    res.filtered_sample = it.value;
                end else begin
                    p = (wr_pos < n) ? wr_pos : 0;
                    hist_mem[p] = it.value;
                    wr_pos = (p + 1 < n) ? p + 1 : 0;
                    // oldest sample first, weighted by coefficient 0
                    acc = '0;
                    j = wr_pos;
                    for (int k = 0; k < n; k++) begin
                        prod = hist_mem[j];
                        prod = prod * coef_mem[k];
                        acc = acc + prod;
                        j = (j + 1 < n) ? j + 1 : 0;
                    end
                    sh = acc >>> FRAC_W;
                    if (sh > SAT_HI) begin
                        res.filtered_sample = 32'h7FFF_FFFF;
                        res.saturated = 1'b1;
                    end else if (sh < SAT_LO) begin
                        res.filtered_sample = 32'h8000_0000;
                        res.saturated = 1'b1;
                    end else begin
                        res.filtered_sample = sh[SAMPLE_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    endtask

    // called just after a falling edge; returns just after a falling edge
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        int gap;
        bit has_out;
        t_out_item res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        apply_item(it, has_out, res);
        if (has_out) filtered_q.push_back(typed ? typed_res : res);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (filtered_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [TAPCNT_W-1:0] taps, input logic en);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TAP_COUNT;
        cfg_data <= taps;
        cfg_taps = taps;
        @(negedge clk);
        cfg_index <= CFG_FILTER_EN;
        cfg_data <= {6'($urandom), en};
        cfg_en = en;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        t_out_item exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (filtered_q.size() == 0) begin
                report_mismatch("unexpected transfer", '0, out_data.filtered_sample);
            end else begin
                exp_r = filtered_q.pop_front();
                if (out_data.filtered_sample !== exp_r.filtered_sample)
                    report_mismatch("filtered_sample", exp_r.filtered_sample,
                                    out_data.filtered_sample);
                if (out_data.saturated !== exp_r.saturated)
                    report_mismatch("saturated", 32'(exp_r.saturated), 32'(out_data.saturated));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver
    initial begin : rx
        int mode;
        int left;
        out_stall = 1'b0;
        mode = 0;
        left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                end
                left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    t_dir_row dir_rows [19];

    initial begin : stim
        t_in_item it;
        int rand_items;
        int phase;
        int phase_len;
        int r;
        logic [TAPCNT_W-1:0] taps;
        logic en;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            hist_mem[i] = '0;
            coef_mem[i] = '0;
        end
        wr_pos = 0;
        cfg_taps = '0;
        cfg_en = 1'b0;

        dir_rows[0]  = dir_row(0, 0, 0, KIND_SAMPLE, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0);
        dir_rows[1]  = dir_row(0, 0, 0, KIND_SAMPLE, 0, 32'h8000_0000, 1, 32'h8000_0000, 0);
        dir_rows[2]  = dir_row(0, 0, 0, KIND_RSVD, 63, 32'hA5A5_A5A5, 0, 0, 0);
        dir_rows[3]  = dir_row(0, 0, 0, KIND_COEF, 0, 32'h7FFF_FFFF, 0, 0, 0);
        dir_rows[4]  = dir_row(0, 0, 0, KIND_COEF, 1, 32'h0800_0000, 0, 0, 0);
        dir_rows[5]  = dir_row(0, 0, 0, KIND_COEF, 2, 32'hF800_0000, 0, 0, 0);
        dir_rows[6]  = dir_row(0, 0, 0, KIND_COEF, 3, 32'h0400_0000, 0, 0, 0);
        dir_rows[7]  = dir_row(0, 0, 0, KIND_COEF, 63, 32'h8000_0000, 0, 0, 0);
        dir_rows[8]  = dir_row(1, 1, 1, KIND_SAMPLE, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
        dir_rows[9]  = dir_row(0, 1, 1, KIND_SAMPLE, 0, 32'h8000_0000, 1, 32'h8000_0000, 1);
        dir_rows[10] = dir_row(0, 1, 1, KIND_SAMPLE, 0, 32'h0000_0000, 1, 32'h0000_0000, 0);
        dir_rows[11] = dir_row(1, 1, 0, KIND_SAMPLE, 5, 32'h1234_5678, 1, 32'h1234_5678, 0);
        dir_rows[12] = dir_row(1, 4, 1, KIND_SAMPLE, 0, 32'h0800_0000, 0, 0, 0);
        dir_rows[13] = dir_row(0, 4, 1, KIND_SAMPLE, 0, 32'hF800_0000, 0, 0, 0);
        dir_rows[14] = dir_row(0, 4, 1, KIND_SAMPLE, 0, 32'h7FFF_FFFF, 0, 0, 0);
        // shrink below the write position
        dir_rows[15] = dir_row(1, 2, 1, KIND_SAMPLE, 0, 32'h0000_0001, 0, 0, 0);
        dir_rows[16] = dir_row(0, 2, 1, KIND_CLEAR, 0, 32'hFFFF_FFFF, 0, 0, 0);
        dir_rows[17] = dir_row(0, 2, 1, KIND_SAMPLE, 0, 32'h8000_0000, 0, 0, 0);
        dir_rows[18] = dir_row(1, 0, 1, KIND_SAMPLE, 0, 32'h5555_5555, 1, 32'h5555_5555, 0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                drain();
                write_cfg(dir_rows[i].taps, dir_rows[i].en);
            end
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        end

        // every coefficient slot gets a value before wide filtering
        drain();
        rand_items = 0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            it.kind = KIND_COEF;
            it.tap_index = TAP_IDX_W'(i);
            it.value = rand_word();
            send_item(it, 0, '0);
            rand_items++;
        end

        phase = 0;
        while (rand_items < RANDOM_ITEMS) begin
            drain();
            case (phase)
                0: taps = 7'd127;
                1: taps = 7'd64;
                2: taps = 7'd65;
                3: taps = 7'd1;
                4: taps = 7'd0;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0) taps = TAPCNT_W'($urandom_range(65, 127));
                    else if (r == 1) taps = 7'd64;
                    else taps = TAPCNT_W'($urandom_range(0, 64));
                end
            endcase
            en = (phase < 4) ? 1'b1 : ($urandom_range(0, 3) != 0);
            write_cfg(taps, en);
            phase_len = (phase == 2) ? 40 : $urandom_range(8, 40);
            if (phase == 2) hold_off_req = 1'b1;
            for (int i = 0; i < phase_len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 76) it.kind = KIND_SAMPLE;
                else if (r < 86) it.kind = KIND_COEF;
                else if (r < 95) it.kind = KIND_CLEAR;
                else it.kind = KIND_RSVD;
                it.tap_index = TAP_IDX_W'($urandom_range(0, 63));
                it.value = rand_word();
                send_item(it, 0, '0);
                if (it.kind != KIND_RSVD) rand_items++;
            end
            phase++;
        end

        drain();
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
